>>> design/lagged_field_autocorrelator_macros.svh
// assertion macros for the lagged field autocorrelator checker
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef LAGGED_FIELD_AUTOCORRELATOR_MACROS_SVH
`define LAGGED_FIELD_AUTOCORRELATOR_MACROS_SVH

// same-cycle implication
`define LFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lfa_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the lagged field autocorrelator; no dependencies
package lfa_pkg;

    localparam int MAX_LAGS   = 64;
    localparam int LAG_W      = $clog2(MAX_LAGS);
    localparam int LAG_CNT_W  = LAG_W + 1;
    localparam int MAX_POINTS = 1024;
    localparam int COL_W      = $clog2(MAX_POINTS);
    localparam int HIST_AW    = LAG_W + COL_W;
    localparam int HIST_DEPTH = MAX_LAGS * MAX_POINTS;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 64;
    localparam int CNT_W      = 32;
    localparam int STEPS_W    = 16;
    localparam int SE_W       = 10;
    localparam int RE_W       = 20;
    localparam int PIN_W      = 11;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(ACC_W);

    localparam logic [SE_W-1:0]      SE_RESET  = SE_W'(10);
    localparam logic [LAG_CNT_W-1:0] NL_RESET  = LAG_CNT_W'(64);
    localparam logic [RE_W-1:0]      RE_RESET  = RE_W'(1000);
    localparam logic [PIN_W-1:0]     PIN_RESET = PIN_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_EVERY  = 2'd0,
        CFG_LAGS_IN_USE   = 2'd1,
        CFG_REPORT_EVERY  = 2'd2,
        CFG_POINTS_IN_USE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic             v_load;
        logic             acc_issue;
        logic             hist_we;
        logic [LAG_W-1:0] lag;
        logic [LAG_W-1:0] slot;
        logic [COL_W-1:0] col;
        logic             mem_rd;
        logic             div_start;
        logic             div_rep;
        logic             upd_wr;
        logic             out_load;
        logic             out_last;
        logic             frame_clear;
        logic [SE_W-1:0]  se;
        logic [PIN_W-1:0] pin;
    } dp_cmd_t;

    typedef struct packed {
        logic acc_busy;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/lfa_div.sv
// iterative signed-by-unsigned divider, one quotient bit a cycle, truncating
// depends on lfa_pkg
module lfa_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lfa_pkg::ACC_W-1:0]    dividend,
    input  logic        [lfa_pkg::CNT_W-1:0]    divisor,
    output logic                                done,
    output logic signed [lfa_pkg::ACC_W-1:0]    quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [lfa_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lfa_pkg::ACC_W-1:0]         quo_reg, quo_next;
    logic [lfa_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [lfa_pkg::CNT_W-1:0]         dsr_reg, dsr_next;
    logic                              neg_reg, neg_next;
    logic [lfa_pkg::CNT_W:0]           trial;
    logic [lfa_pkg::CNT_W:0]           diff;
    logic                              ge;
    logic [lfa_pkg::ACC_W-1:0]         mag;

    assign mag   = dividend[lfa_pkg::ACC_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, quo_reg[lfa_pkg::ACC_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = mag;
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[lfa_pkg::ACC_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[lfa_pkg::CNT_W-1:0] : trial[lfa_pkg::CNT_W-1:0];
            quo_next = {quo_reg[lfa_pkg::ACC_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lfa_pkg::DIV_CNT_W'(lfa_pkg::ACC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);

endmodule

>>> design/lfa_datapath.sv
// datapath: history ring memory, lag product pipeline, frame/lag/count memories,
// shared divider and output register; depends on lfa_pkg and lfa_div
module lfa_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfa_pkg::dp_cmd_t                    cmd,
    output lfa_pkg::dp_status_t                 status,
    input  logic signed [lfa_pkg::VAL_W-1:0]    point_value,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [lfa_pkg::LAG_W-1:0]           lag_index,
    output logic [lfa_pkg::STEPS_W-1:0]         lag_steps,
    output logic [lfa_pkg::CNT_W-1:0]           sample_count,
    output logic signed [lfa_pkg::ACC_W-1:0]    average,
    output logic                                last_lag
);

    localparam logic signed [lfa_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(lfa_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [lfa_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(lfa_pkg::ACC_W-1){1'b0}}};

    function automatic logic signed [lfa_pkg::ACC_W-1:0] sat_add
    (
        input logic signed [lfa_pkg::ACC_W-1:0] a,
        input logic signed [lfa_pkg::ACC_W-1:0] b
    );
        logic signed [lfa_pkg::ACC_W-1:0] s;
        s = a + b;
        if (a[lfa_pkg::ACC_W-1] == b[lfa_pkg::ACC_W-1] &&
            s[lfa_pkg::ACC_W-1] != a[lfa_pkg::ACC_W-1])
        begin
            s = a[lfa_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    logic signed [lfa_pkg::VAL_W-1:0]  hist_mem [lfa_pkg::HIST_DEPTH];
    logic signed [lfa_pkg::ACC_W-1:0]  frame_mem [lfa_pkg::MAX_LAGS];
    logic signed [lfa_pkg::ACC_W-1:0]  ls_mem [lfa_pkg::MAX_LAGS];
    logic        [lfa_pkg::CNT_W-1:0]  cnt_mem [lfa_pkg::MAX_LAGS];

    logic signed [lfa_pkg::VAL_W-1:0]  v_reg;
    logic signed [lfa_pkg::VAL_W-1:0]  hist_rd_reg;
    logic [lfa_pkg::HIST_AW-1:0]       hist_addr;

    logic                              s1_valid_reg, s2_valid_reg;
    logic [lfa_pkg::LAG_W-1:0]         s1_lag_reg, s2_lag_reg;
    logic                              s1_lag0_reg;
    logic signed [lfa_pkg::ACC_W-1:0]  prod_reg;
    logic signed [lfa_pkg::ACC_W-1:0]  s2_frame_reg;
    logic signed [lfa_pkg::VAL_W-1:0]  mul_b;
    logic signed [lfa_pkg::ACC_W-1:0]  prod_c;

    logic signed [lfa_pkg::ACC_W-1:0]  frame_rd_reg, ls_rd_reg;
    logic        [lfa_pkg::CNT_W-1:0]  cnt_rd_reg;
    logic                              frame_vld_rd_reg, ls_vld_rd_reg;
    logic [lfa_pkg::MAX_LAGS-1:0]      frame_vld_reg, ls_vld_reg;

    logic signed [lfa_pkg::ACC_W-1:0]  frame_eff, ls_eff;
    logic        [lfa_pkg::CNT_W-1:0]  cnt_eff;
    logic signed [lfa_pkg::ACC_W-1:0]  div_dividend;
    logic        [lfa_pkg::CNT_W-1:0]  div_divisor;
    logic                              div_done;
    logic signed [lfa_pkg::ACC_W-1:0]  div_quot;

    logic                              out_valid_reg;
    logic [lfa_pkg::LAG_W-1:0]         lag_index_reg;
    logic [lfa_pkg::STEPS_W-1:0]       lag_steps_reg;
    logic [lfa_pkg::CNT_W-1:0]         sample_count_reg;
    logic signed [lfa_pkg::ACC_W-1:0]  average_reg;
    logic                              last_lag_reg;

    assign hist_addr = {cmd.slot, cmd.col};

    always_ff @(posedge clk)
    begin
        if (cmd.v_load)
        begin
            v_reg <= point_value;
        end
        if (cmd.hist_we)
        begin
            hist_mem[hist_addr] <= v_reg;
        end
        if (cmd.acc_issue)
        begin
            hist_rd_reg <= hist_mem[hist_addr];
        end
    end

    // lag 0 pairs the current sample with itself
    assign mul_b  = s1_lag0_reg ? v_reg : hist_rd_reg;
    assign prod_c = v_reg * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.acc_issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lag_reg   <= cmd.lag;
        s1_lag0_reg  <= (cmd.lag == '0);
        s2_lag_reg   <= s1_lag_reg;
        prod_reg     <= prod_c;
        s2_frame_reg <= frame_vld_rd_reg ? frame_rd_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_issue || cmd.mem_rd)
        begin
            frame_rd_reg <= frame_mem[cmd.lag];
        end
        if (cmd.mem_rd)
        begin
            ls_rd_reg  <= ls_mem[cmd.lag];
            cnt_rd_reg <= cnt_mem[cmd.lag];
        end
        if (s2_valid_reg)
        begin
            frame_mem[s2_lag_reg] <= sat_add(s2_frame_reg, prod_reg);
        end
        if (cmd.upd_wr)
        begin
            ls_mem[cmd.lag]  <= sat_add(ls_eff, div_quot);
            cnt_mem[cmd.lag] <= (&cnt_eff) ? cnt_eff : cnt_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_vld_reg    <= '0;
            ls_vld_reg       <= '0;
            frame_vld_rd_reg <= 1'b0;
            ls_vld_rd_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.frame_clear)
            begin
                frame_vld_reg <= '0;
            end
            else if (s2_valid_reg)
            begin
                frame_vld_reg[s2_lag_reg] <= 1'b1;
            end
            if (cmd.upd_wr)
            begin
                ls_vld_reg[cmd.lag] <= 1'b1;
            end
            if (cmd.acc_issue || cmd.mem_rd)
            begin
                frame_vld_rd_reg <= frame_vld_reg[cmd.lag];
            end
            if (cmd.mem_rd)
            begin
                ls_vld_rd_reg <= ls_vld_reg[cmd.lag];
            end
        end
    end

    assign frame_eff = frame_vld_rd_reg ? frame_rd_reg : '0;
    assign ls_eff    = ls_vld_rd_reg ? ls_rd_reg : '0;
    assign cnt_eff   = ls_vld_rd_reg ? cnt_rd_reg : '0;

    assign div_dividend = cmd.div_rep ? ls_eff : frame_eff;
    assign div_divisor  = cmd.div_rep ? cnt_eff
                                      : {{(lfa_pkg::CNT_W-lfa_pkg::PIN_W){1'b0}}, cmd.pin};

    lfa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            lag_index_reg    <= cmd.lag;
            lag_steps_reg    <= lfa_pkg::STEPS_W'(
                                    {{(lfa_pkg::STEPS_W-lfa_pkg::LAG_W){1'b0}}, cmd.lag} *
                                    {{(lfa_pkg::STEPS_W-lfa_pkg::SE_W){1'b0}}, cmd.se});
            sample_count_reg <= cnt_eff;
            average_reg      <= (cnt_eff == '0) ? '0 : div_quot;
            last_lag_reg     <= cmd.out_last;
        end
    end

    assign status.acc_busy = s1_valid_reg | s2_valid_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign lag_index    = lag_index_reg;
    assign lag_steps    = lag_steps_reg;
    assign sample_count = sample_count_reg;
    assign average      = average_reg;
    assign last_lag     = last_lag_reg;

endmodule

>>> design/lfa_ctrl.sv
// controller: configuration registers, step bookkeeping and the sequencing fsm
// depends on lfa_pkg; drives the datapath through lfa_pkg::dp_cmd_t
module lfa_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               last_point,
    input  logic                               cfg_we,
    input  logic [lfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lfa_pkg::CFG_W-1:0]          cfg_data,
    output lfa_pkg::dp_cmd_t                   cmd,
    input  lfa_pkg::dp_status_t                status
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_ACC      = 12'b0000_0000_0010,
        ST_DRAIN    = 12'b0000_0000_0100,
        ST_UPD_RD   = 12'b0000_0000_1000,
        ST_UPD_GO   = 12'b0000_0001_0000,
        ST_UPD_WAIT = 12'b0000_0010_0000,
        ST_UPD_WR   = 12'b0000_0100_0000,
        ST_REP_RD   = 12'b0000_1000_0000,
        ST_REP_GO   = 12'b0001_0000_0000,
        ST_REP_WAIT = 12'b0010_0000_0000,
        ST_REP_OUT  = 12'b0100_0000_0000,
        ST_FIN      = 12'b1000_0000_0000
    } state_t;

    state_t                             state_reg, state_next;
    logic [lfa_pkg::SE_W-1:0]           se_cfg_reg;
    logic [lfa_pkg::LAG_CNT_W-1:0]      nl_cfg_reg;
    logic [lfa_pkg::RE_W-1:0]           re_cfg_reg;
    logic [lfa_pkg::PIN_W-1:0]          pin_cfg_reg;

    logic [lfa_pkg::LAG_W-1:0]          ws_reg, ws_next;
    logic [lfa_pkg::LAG_CNT_W-1:0]      fill_reg, fill_next;
    logic [lfa_pkg::COL_W-1:0]          pc_reg, pc_next;
    logic [lfa_pkg::COL_W-1:0]          col_reg, col_next;
    logic [lfa_pkg::SE_W-1:0]           sph_reg, sph_next;
    logic [lfa_pkg::RE_W-1:0]           rph_reg, rph_next;
    logic                               past_first_reg, past_first_next;
    logic                               mid_reg, mid_next;
    logic                               last_item_reg, last_item_next;
    logic [lfa_pkg::LAG_W-1:0]          lag_reg, lag_next;

    logic [lfa_pkg::LAG_CNT_W-1:0]      nl;
    logic [lfa_pkg::SE_W-1:0]           se_eff;
    logic [lfa_pkg::RE_W-1:0]           re_eff;
    logic [lfa_pkg::PIN_W-1:0]          pin_eff;
    logic                               accept;
    logic                               used;
    logic                               report_due;
    logic [lfa_pkg::LAG_CNT_W-1:0]      ws_inc;
    logic [lfa_pkg::LAG_CNT_W-1:0]      fill_adv;
    logic [lfa_pkg::LAG_CNT_W-1:0]      lag_inc;
    logic [lfa_pkg::LAG_CNT_W-1:0]      slot_wide;
    logic                               lag_last_fill;
    logic                               lag_last_nl;

    always_comb
    begin
        if (nl_cfg_reg == '0)
        begin
            nl = lfa_pkg::LAG_CNT_W'(1);
        end
        else if (nl_cfg_reg > lfa_pkg::LAG_CNT_W'(lfa_pkg::MAX_LAGS))
        begin
            nl = lfa_pkg::LAG_CNT_W'(lfa_pkg::MAX_LAGS);
        end
        else
        begin
            nl = nl_cfg_reg;
        end
    end

    assign se_eff  = (se_cfg_reg == '0) ? lfa_pkg::SE_W'(1) : se_cfg_reg;
    assign re_eff  = (re_cfg_reg == '0) ? lfa_pkg::RE_W'(1) : re_cfg_reg;
    assign pin_eff = (pin_cfg_reg == '0) ? lfa_pkg::PIN_W'(1) : pin_cfg_reg;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign used       = (sph_reg == '0);
    assign report_due = past_first_reg && (rph_reg == '0);
    assign ws_inc     = {1'b0, ws_reg} + 1'b1;
    assign lag_inc    = {1'b0, lag_reg} + 1'b1;
    assign lag_last_fill = (lag_inc == fill_reg);
    assign lag_last_nl   = (lag_inc == nl);

    // ring slot of the sample lag_reg steps back
    assign slot_wide = {1'b0, ws_reg} - {1'b0, lag_reg} + ((ws_reg < lag_reg) ? nl : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_cfg_reg  <= lfa_pkg::SE_RESET;
            nl_cfg_reg  <= lfa_pkg::NL_RESET;
            re_cfg_reg  <= lfa_pkg::RE_RESET;
            pin_cfg_reg <= lfa_pkg::PIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lfa_pkg::cfg_idx_t'(cfg_index))
                lfa_pkg::CFG_SAMPLE_EVERY:  se_cfg_reg  <= cfg_data[lfa_pkg::SE_W-1:0];
                lfa_pkg::CFG_LAGS_IN_USE:   nl_cfg_reg  <= cfg_data[lfa_pkg::LAG_CNT_W-1:0];
                lfa_pkg::CFG_REPORT_EVERY:  re_cfg_reg  <= cfg_data[lfa_pkg::RE_W-1:0];
                lfa_pkg::CFG_POINTS_IN_USE: pin_cfg_reg <= cfg_data[lfa_pkg::PIN_W-1:0];
                default:                    se_cfg_reg  <= se_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ws_next         = ws_reg;
        fill_next       = fill_reg;
        pc_next         = pc_reg;
        col_next        = col_reg;
        sph_next        = sph_reg;
        rph_next        = rph_reg;
        past_first_next = past_first_reg;
        mid_next        = mid_reg;
        last_item_next  = last_item_reg;
        lag_next        = lag_reg;
        fill_adv        = fill_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mid_next       = 1'b1;
                    last_item_next = last_point;
                    col_next       = pc_reg;
                    if (pc_reg != lfa_pkg::COL_W'(lfa_pkg::MAX_POINTS - 1))
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    // step start opens the next ring slot
                    if (!mid_reg && used)
                    begin
                        ws_next  = (ws_inc >= nl) ? '0 : ws_inc[lfa_pkg::LAG_W-1:0];
                        fill_adv = (fill_reg < nl) ? fill_reg + 1'b1 : fill_reg;
                    end
                    fill_next = (fill_adv > nl) ? nl : fill_adv;
                    lag_next  = '0;
                    if (used)
                    begin
                        state_next = ST_ACC;
                    end
                    else if (last_point)
                    begin
                        state_next = report_due ? ST_REP_RD : ST_FIN;
                    end
                end
            end
            ST_ACC:
            begin
                if (lag_last_fill)
                begin
                    lag_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    lag_next = lag_inc[lfa_pkg::LAG_W-1:0];
                end
            end
            ST_DRAIN:
            begin
                if (!status.acc_busy)
                begin
                    state_next = last_item_reg ? ST_UPD_RD : ST_IDLE;
                end
            end
            ST_UPD_RD:   state_next = ST_UPD_GO;
            ST_UPD_GO:   state_next = ST_UPD_WAIT;
            ST_UPD_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPD_WR;
                end
            end
            ST_UPD_WR:
            begin
                if (lag_last_fill)
                begin
                    lag_next   = '0;
                    state_next = report_due ? ST_REP_RD : ST_FIN;
                end
                else
                begin
                    lag_next   = lag_inc[lfa_pkg::LAG_W-1:0];
                    state_next = ST_UPD_RD;
                end
            end
            ST_REP_RD:   state_next = ST_REP_GO;
            ST_REP_GO:   state_next = ST_REP_WAIT;
            ST_REP_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_REP_OUT;
                end
            end
            ST_REP_OUT:
            begin
                if (status.out_free)
                begin
                    if (lag_last_nl)
                    begin
                        lag_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        lag_next   = lag_inc[lfa_pkg::LAG_W-1:0];
                        state_next = ST_REP_RD;
                    end
                end
            end
            ST_FIN:
            begin
                sph_next = ({1'b0, sph_reg} + 1'b1 >= {1'b0, se_eff}) ? '0 : sph_reg + 1'b1;
                rph_next = ({1'b0, rph_reg} + 1'b1 >= {1'b0, re_eff}) ? '0 : rph_reg + 1'b1;
                past_first_next = 1'b1;
                pc_next         = '0;
                mid_next        = 1'b0;
                state_next      = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ws_reg         <= lfa_pkg::LAG_W'(lfa_pkg::MAX_LAGS - 1);
            fill_reg       <= '0;
            pc_reg         <= '0;
            col_reg        <= '0;
            sph_reg        <= '0;
            rph_reg        <= '0;
            past_first_reg <= 1'b0;
            mid_reg        <= 1'b0;
            last_item_reg  <= 1'b0;
            lag_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ws_reg         <= ws_next;
            fill_reg       <= fill_next;
            pc_reg         <= pc_next;
            col_reg        <= col_next;
            sph_reg        <= sph_next;
            rph_reg        <= rph_next;
            past_first_reg <= past_first_next;
            mid_reg        <= mid_next;
            last_item_reg  <= last_item_next;
            lag_reg        <= lag_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    assign cmd.v_load      = accept;
    assign cmd.acc_issue   = (state_reg == ST_ACC);
    assign cmd.hist_we     = (state_reg == ST_ACC) && (lag_reg == '0);
    assign cmd.lag         = lag_reg;
    assign cmd.slot        = slot_wide[lfa_pkg::LAG_W-1:0];
    assign cmd.col         = col_reg;
    assign cmd.mem_rd      = (state_reg == ST_UPD_RD) || (state_reg == ST_REP_RD);
    assign cmd.div_start   = (state_reg == ST_UPD_GO) || (state_reg == ST_REP_GO);
    assign cmd.div_rep     = (state_reg == ST_REP_GO);
    assign cmd.upd_wr      = (state_reg == ST_UPD_WR);
    assign cmd.out_load    = (state_reg == ST_REP_OUT) && status.out_free;
    assign cmd.out_last    = lag_last_nl;
    assign cmd.frame_clear = (state_reg == ST_FIN);
    assign cmd.se          = se_eff;
    assign cmd.pin         = pin_eff;

endmodule

>>> design/lagged_field_autocorrelator.sv
// top level of the lagged field autocorrelator
// depends on lfa_pkg, lfa_ctrl, lfa_datapath (and lfa_div below it)
//
// usage:
//   input channel: one field point per beat (point_value, last_point), in_valid/in_stall;
//   last_point closes a step. output channel: one beat per lag of a report
//   (lag_index .. last_lag), out_valid/out_stall; last_lag marks the final beat.
//   configuration: cfg_we/cfg_index/cfg_data, to be written by the user only while the
//   block is idle; the block itself does not enforce this.
// sequence:
//   an unused-step point is taken in idle; a used-step point adds one multiplier pass
//   over the stored lags. closing a used step adds a shared-divider pass and write per
//   filled lag; a report adds a divider pass per lag, plus any output stall time. the
//   first result beat of a report follows the closing step's lag updates, or the
//   closing point of an unused step.
// reset: all counters, running sums and counts clear, the ring write slot points at
//   the last slot, registers take their defaults; the history memory holds garbage
//   until written and needs no clearing pass.
// stall: a held result stays stable; the next lag is computed and waits behind the
//   output register, and new points are taken once the report has been queued out.
module lagged_field_autocorrelator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lfa_pkg::VAL_W-1:0]    point_value,
    input  logic                                last_point,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lfa_pkg::LAG_W-1:0]           lag_index,
    output logic [lfa_pkg::STEPS_W-1:0]         lag_steps,
    output logic [lfa_pkg::CNT_W-1:0]           sample_count,
    output logic signed [lfa_pkg::ACC_W-1:0]    average,
    output logic                                last_lag,
    input  logic                                cfg_we,
    input  logic [lfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfa_pkg::CFG_W-1:0]           cfg_data
);

    lfa_pkg::dp_cmd_t    cmd;
    lfa_pkg::dp_status_t status;

    lfa_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_point (last_point),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status)
    );

    lfa_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .point_value  (point_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .lag_index    (lag_index),
        .lag_steps    (lag_steps),
        .sample_count (sample_count),
        .average      (average),
        .last_lag     (last_lag)
    );

endmodule

>>> design/lfa_checker.sv
// port-level checker for the lagged field autocorrelator, bound to the top level
// depends on lfa_pkg and lagged_field_autocorrelator_macros.svh
`include "lagged_field_autocorrelator_macros.svh"

module lfa_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                last_point,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [lfa_pkg::LAG_W-1:0]           lag_index,
    input logic [lfa_pkg::STEPS_W-1:0]         lag_steps,
    input logic [lfa_pkg::CNT_W-1:0]           sample_count,
    input logic signed [lfa_pkg::ACC_W-1:0]    average,
    input logic                                last_lag
);

    // held result beat keeps its payload
    `LFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(average) && $stable(lag_index) && $stable(last_lag),
        "stalled result beat changed")

    // a mid-step point never starts a report
    `LFA_ASSERT_NEXT(a_no_report_mid_step, in_valid && !in_stall && !last_point,
        !$rose(out_valid), "result started after a point that does not close a step")

    // an empty lag averages to zero
    `LFA_ASSERT_NOW(a_empty_lag_zero, out_valid && sample_count == '0,
        average == '0, "nonzero average for empty lag")

    // lag zero spans no steps
    `LFA_ASSERT_NOW(a_lag0_steps, out_valid && lag_index == '0,
        lag_steps == '0, "lag zero with nonzero step span")

endmodule

bind lagged_field_autocorrelator lfa_checker u_lfa_checker (.*);
